### rtl/ovl_pkg.sv
// ovl_pkg: shared types and codes for the ordered value list.
// No dependencies; imported by ordered_value_list.

package ovl_pkg;

    // Command codes carried by an input item
    typedef enum logic [2:0] {
        CMD_APPEND = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_DELETE = 3'd2,
        CMD_SEARCH = 3'd3,
        CMD_READ   = 3'd4,
        CMD_CLEAR  = 3'd5
    } cmd_t;

    // Result status codes
    typedef enum logic [1:0] {
        STS_DONE = 2'd0,
        STS_MISS = 2'd1,
        STS_FULL = 2'd2
    } status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_SHIFT,
        S_READ_WAIT
    } state_t;

endpackage

### rtl/ovl_ram.sv
// ovl_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.

module ovl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/ordered_value_list.sv
// ordered_value_list: bounded ordered list of signed 32-bit values, top level.
// Depends on ovl_pkg (types, codes) and ovl_ram (entry store).
//
// Usage
//   An item (command, operand_value, position) is taken at a rising edge with
//   start high and busy low. busy stays high while the item is worked on.
//   Exactly one result per item: status, found, read_value and entry_count
//   are valid for the single cycle in which done is high. The receiver has
//   no way to hold a result back; it must take it in that cycle.
// Steps from the accepting edge to the done cycle
//   append, insert, clear, unused codes, out-of-range read: done from S_EXEC
//   read at index: store read issued in S_EXEC, data taken in S_READ_WAIT
//   search: S_SCAN up to the hit or the end (one entry compared per cycle)
//   delete: S_SCAN as for search; on a hit S_SHIFT then closes the gap one
//   entry per cycle
// The scan and the close-up pass each walk one slot a cycle through the single
// read and single write port of the entry store.
// Throughput: one item at a time; the next start may come in the done cycle.
// Reset (rst_n low, asynchronous) empties the list and clears done/busy.
// The entry store itself is not cleared: only written slots are ever read.
// Storage is a circular buffer: front_reg marks the first entry.

module ordered_value_list
    import ovl_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         command,
    input  logic signed [31:0] operand_value,
    input  logic [5:0]         position,
    output logic               done,
    output logic [1:0]         status,
    output logic               found,
    output logic signed [31:0] read_value,
    output logic [6:0]         entry_count
);

    localparam int AW = $clog2(CAPACITY);       // slot address width
    localparam int CW = $clog2(CAPACITY + 1);   // count width, holds CAPACITY
    localparam int SW = ((AW > 6) ? AW : 6) + 2; // slot adder / compare width

    localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);
    localparam logic [SW-1:0] CAP_S     = SW'(CAPACITY);

    function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] p);
        slot_inc = (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    // Sequencer and item registers
    state_t             state_reg, state_next;
    logic [2:0]         cmd_reg, cmd_next;
    logic [31:0]        val_reg, val_next;
    logic [5:0]         pos_reg, pos_next;

    // List state
    logic [AW-1:0]      front_reg, front_next;
    logic [CW-1:0]      count_reg, count_next;

    // Walk state: scan index, moves left, pointers, read-in-flight flag
    logic [CW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      left_reg, left_next;
    logic [AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]      prev_ptr_reg, prev_ptr_next;
    logic               pend_reg, pend_next;

    // Result registers
    logic               done_reg, done_next;
    logic [1:0]         status_reg, status_next;
    logic               found_reg, found_next;
    logic [31:0]        rv_reg, rv_next;
    logic [6:0]         ecount_reg, ecount_next;

    // Store ports
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [31:0]        mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [31:0]        mem_rdata;

    // Shared slot adder: front + offset, wrapped once
    logic [SW-1:0]      slot_off;
    logic [SW-1:0]      slot_sum;
    logic [AW-1:0]      slot_addr;

    logic               is_full;
    logic               pos_hit;
    logic               more_scan;
    logic               match;
    logic [AW-1:0]      front_dec;

    ovl_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    always_comb
    begin
        slot_off  = (cmd_reg == CMD_READ) ? SW'(pos_reg) : SW'(count_reg);
        slot_sum  = SW'(front_reg) + slot_off;
        if (slot_sum >= CAP_S)
        begin
            slot_sum = slot_sum - CAP_S;
        end
        slot_addr = slot_sum[AW-1:0];
    end

    assign is_full   = (SW'(count_reg) >= CAP_S);
    assign pos_hit   = (SW'(pos_reg) < SW'(count_reg));
    assign more_scan = (idx_reg < count_reg);
    assign match     = pend_reg && (mem_rdata == val_reg);
    assign front_dec = (front_reg == '0) ? LAST_SLOT : front_reg - 1'b1;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (cmd_reg) inside
                    CMD_DELETE, CMD_SEARCH: state_next = S_SCAN;
                    CMD_READ:   state_next = pos_hit ? S_READ_WAIT : S_IDLE;
                    default:    state_next = S_IDLE;
                endcase
            end
            S_SCAN:
            begin
                if (match)
                begin
                    state_next = (cmd_reg == CMD_DELETE) ? S_SHIFT : S_IDLE;
                end
                else if (!more_scan)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SHIFT:
            begin
                if (left_reg == '0 && !pend_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ_WAIT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        cmd_next      = cmd_reg;
        val_next      = val_reg;
        pos_next      = pos_reg;
        front_next    = front_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        left_next     = left_reg;
        rd_ptr_next   = rd_ptr_reg;
        wr_ptr_next   = wr_ptr_reg;
        prev_ptr_next = prev_ptr_reg;
        pend_next     = 1'b0;
        done_next     = 1'b0;
        status_next   = status_reg;
        found_next    = found_reg;
        rv_next       = rv_reg;
        ecount_next   = ecount_reg;

        mem_we        = 1'b0;
        mem_waddr     = wr_ptr_reg;
        mem_wdata     = mem_rdata;
        mem_raddr     = rd_ptr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = command;
                    val_next = operand_value;
                    pos_next = position;
                end
            end
            S_EXEC:
            begin
                done_next   = 1'b1;
                status_next = STS_DONE;
                found_next  = 1'b0;
                rv_next     = '0;
                unique case (cmd_reg) inside
                    CMD_APPEND:
                    begin
                        if (is_full)
                        begin
                            status_next = STS_FULL;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = slot_addr;
                            mem_wdata  = val_reg;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    CMD_INSERT:
                    begin
                        if (is_full)
                        begin
                            status_next = STS_FULL;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = front_dec;
                            mem_wdata  = val_reg;
                            front_next = front_dec;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    CMD_DELETE, CMD_SEARCH:
                    begin
                        done_next   = 1'b0;
                        idx_next    = '0;
                        rd_ptr_next = front_reg;
                    end
                    CMD_READ:
                    begin
                        if (pos_hit)
                        begin
                            done_next = 1'b0;
                            mem_raddr = slot_addr;
                        end
                        else
                        begin
                            status_next = STS_MISS;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        front_next = '0;
                        count_next = '0;
                    end
                    default:
                    begin
                        // unused codes: no change, plain done
                    end
                endcase
            end
            S_SCAN:
            begin
                // issue the next read while comparing the one in flight
                if (more_scan)
                begin
                    mem_raddr     = rd_ptr_reg;
                    prev_ptr_next = rd_ptr_reg;
                    rd_ptr_next   = slot_inc(rd_ptr_reg);
                    idx_next      = idx_reg + 1'b1;
                    pend_next     = 1'b1;
                end
                if (match)
                begin
                    if (cmd_reg == CMD_DELETE)
                    begin
                        // close up from the hit slot onward
                        wr_ptr_next = prev_ptr_reg;
                        rd_ptr_next = rd_ptr_reg;
                        left_next   = count_reg - idx_reg;
                        pend_next   = 1'b0;
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        status_next = STS_DONE;
                        found_next  = 1'b1;
                        rv_next     = '0;
                    end
                end
                else if (!more_scan)
                begin
                    done_next   = 1'b1;
                    status_next = STS_MISS;
                    found_next  = 1'b0;
                    rv_next     = '0;
                end
            end
            S_SHIFT:
            begin
                if (pend_reg)
                begin
                    mem_we      = 1'b1;
                    mem_waddr   = wr_ptr_reg;
                    mem_wdata   = mem_rdata;
                    wr_ptr_next = slot_inc(wr_ptr_reg);
                end
                if (left_reg != '0)
                begin
                    mem_raddr   = rd_ptr_reg;
                    rd_ptr_next = slot_inc(rd_ptr_reg);
                    left_next   = left_reg - 1'b1;
                    pend_next   = 1'b1;
                end
                else if (!pend_reg)
                begin
                    count_next  = count_reg - 1'b1;
                    done_next   = 1'b1;
                    status_next = STS_DONE;
                    found_next  = 1'b1;
                    rv_next     = '0;
                end
            end
            S_READ_WAIT:
            begin
                done_next   = 1'b1;
                status_next = STS_DONE;
                found_next  = 1'b1;
                rv_next     = mem_rdata;
            end
            default:
            begin
            end
        endcase

        ecount_next = 7'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            front_reg <= '0;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    // Payload, walk and result registers, no reset needed
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        val_reg      <= val_next;
        pos_reg      <= pos_next;
        idx_reg      <= idx_next;
        left_reg     <= left_next;
        rd_ptr_reg   <= rd_ptr_next;
        wr_ptr_reg   <= wr_ptr_next;
        prev_ptr_reg <= prev_ptr_next;
        status_reg   <= status_next;
        found_reg    <= found_next;
        rv_reg       <= rv_next;
        ecount_reg   <= ecount_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign read_value  = rv_reg;
    assign entry_count = ecount_reg;

endmodule

### bench/tb_ordered_value_list.sv
// tb_ordered_value_list: self-checking bench for the ordered value list.
// Depends on ovl_pkg (command and status codes) and ordered_value_list (the block).
// Holds its own list predictor and checks each result field by field.

module tb_ordered_value_list
    import ovl_pkg::*;
();

    localparam int CAPACITY      = 64;
    localparam int RANDOM_ITEMS  = 1130;
    // Settle well past the worst delete on a full list
    localparam int SETTLE_CYCLES = 2 * CAPACITY + 8;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PRINT_LIMIT   = 30;

    // Command codes that the package leaves unnamed: the block must treat them as no-ops
    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;

    // Episode shapes for the random part
    localparam int EP_FILL  = 0;
    localparam int EP_DRAIN = 1;
    localparam int EP_MIXED = 2;
    localparam int EP_NOISE = 3;

    // One command waiting to go out, with its idling policy attached
    typedef struct {
        logic [2:0]  cmd;
        logic [31:0] value;
        logic [5:0]  pos;
        int          gap_pct;         // chance per cycle that the sender idles
        bit          hold_for_drain;  // wait until no result is outstanding
    } pending_cmd_t;

    // What the block must report for one command
    typedef struct {
        status_t     status;
        logic        found;
        logic [31:0] read_value;
        logic [6:0]  entry_count;
    } outcome_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [2:0]         command = CMD_APPEND;
    logic signed [31:0] operand_value = '0;
    logic [5:0]         position = '0;
    logic               busy;
    logic               done;
    logic [1:0]         status;
    logic               found;
    logic signed [31:0] read_value;
    logic [6:0]         entry_count;

    pending_cmd_t queued_commands[$];
    outcome_t     awaited_results[$];
    logic [31:0]  shadow_list[$];     // predicted list contents, front first
    logic [31:0]  value_pool[16];     // small set of values so deletes and searches hit

    logic taken = 1'b0;               // item on the ports was accepted at the last edge
    int   gap_now = 0;
    bit   hold_next = 1'b0;
    int   fail_count = 0;
    int   results_seen = 0;
    int   full_seen = 0;
    int   hits_seen = 0;
    int   cycle_count = 0;
    int   cmd_seen[8];

    ordered_value_list #(
        .CAPACITY(CAPACITY)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .command(command),
        .operand_value(operand_value),
        .position(position),
        .done(done),
        .status(status),
        .found(found),
        .read_value(read_value),
        .entry_count(entry_count)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Predictor: applies one command to the shadow list
    // ---------------------------------------------------------------
    function automatic outcome_t apply_command(logic [2:0] cmd, logic [31:0] value,
                                               logic [5:0] pos);
        outcome_t r;
        int       hit;
        r.status = STS_DONE;
        r.found = 1'b0;
        r.read_value = '0;
        hit = -1;
        // first entry equal to the operand, all 32 bits compared
        for (int k = 0; k < shadow_list.size(); k++)
        begin
            if (hit < 0 && shadow_list[k] == value)
                hit = k;
        end
        case (cmd)
            CMD_APPEND:
                if (shadow_list.size() >= CAPACITY)
                    r.status = STS_FULL;
                else
                    shadow_list.push_back(value);
            CMD_INSERT:
                if (shadow_list.size() >= CAPACITY)
                    r.status = STS_FULL;
                else
                    shadow_list.push_front(value);
            CMD_DELETE:
                if (hit < 0)
                    r.status = STS_MISS;
                else
                begin
                    r.found = 1'b1;
                    shadow_list.delete(hit);   // later entries close up
                end
            CMD_SEARCH:
                if (hit < 0)
                    r.status = STS_MISS;
                else
                    r.found = 1'b1;
            CMD_READ:
                if (int'(pos) < shadow_list.size())
                begin
                    r.found = 1'b1;
                    r.read_value = shadow_list[pos];
                end
                else
                    r.status = STS_MISS;
            CMD_CLEAR:
                shadow_list.delete();
            default:
                ;   // spare codes leave everything alone
        endcase
        r.entry_count = 7'(shadow_list.size());
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic queue_item(logic [2:0] cmd, logic [31:0] value, logic [5:0] pos);
        pending_cmd_t p;
        p.cmd = cmd;
        p.value = value;
        p.pos = pos;
        p.gap_pct = gap_now;
        p.hold_for_drain = hold_next;
        hold_next = 1'b0;
        queued_commands.push_back(p);
    endtask

    // mostly pool values so that duplicates build up; now and then anything
    function automatic logic [31:0] pick_value();
        if ($urandom_range(99) < 80)
            return value_pool[$urandom_range(15)];
        return $urandom;
    endfunction

    // cumulative weights: append, insert, delete, search, read, clear; rest spare
    function automatic logic [2:0] pick_command(int kind);
        int roll;
        int lim_app, lim_ins, lim_del, lim_src, lim_rd, lim_clr;
        roll = $urandom_range(99);
        case (kind)
            EP_FILL:
            begin
                lim_app = 40; lim_ins = 75; lim_del = 78;
                lim_src = 88; lim_rd = 98; lim_clr = 99;
            end
            EP_DRAIN:
            begin
                lim_app = 5; lim_ins = 8; lim_del = 63;
                lim_src = 78; lim_rd = 93; lim_clr = 95;
            end
            default:
            begin
                lim_app = 18; lim_ins = 34; lim_del = 52;
                lim_src = 68; lim_rd = 84; lim_clr = 88;
            end
        endcase
        if (roll < lim_app) return CMD_APPEND;
        if (roll < lim_ins) return CMD_INSERT;
        if (roll < lim_del) return CMD_DELETE;
        if (roll < lim_src) return CMD_SEARCH;
        if (roll < lim_rd)  return CMD_READ;
        if (roll < lim_clr) return CMD_CLEAR;
        return ($urandom_range(1) != 0) ? CMD_SPARE_B : CMD_SPARE_A;
    endfunction

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------
    task automatic report_mismatch(string what);
        fail_count++;
        if (fail_count <= PRINT_LIMIT)
            $display("MISMATCH: %s", what);
    endtask

    task automatic check_field(string name, int idx, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %h want %h", idx, name, got, want));
    endtask

    // ---------------------------------------------------------------
    // Driver: presents queued items at the falling edge
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin : driver
        pending_cmd_t nxt;
        logic         present;
        present = 1'b0;
        // hold an item that has not been taken yet
        if (rst_n && !(start && !taken))
        begin
            if (queued_commands.size() != 0)
            begin
                nxt = queued_commands[0];
                if (nxt.hold_for_drain && awaited_results.size() != 0)
                    present = 1'b0;
                else if ($urandom_range(99) < nxt.gap_pct)
                    present = 1'b0;
                else
                begin
                    present = 1'b1;
                    void'(queued_commands.pop_front());
                end
            end
            start <= present;
            if (present)
            begin
                command       <= nxt.cmd;
                operand_value <= nxt.value;
                position      <= nxt.pos;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: results first, then acceptance, all at the rising edge
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        outcome_t want;
        if (done)
        begin
            results_seen++;
            if (awaited_results.size() == 0)
                report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                          results_seen));
            else
            begin
                want = awaited_results.pop_front();
                check_field("status", results_seen, 32'(status), 32'(want.status));
                check_field("found", results_seen, 32'(found), 32'(want.found));
                check_field("read_value", results_seen, read_value, want.read_value);
                check_field("entry_count", results_seen, 32'(entry_count),
                            32'(want.entry_count));
                if (want.status == STS_FULL)
                    full_seen++;
                if (want.found)
                    hits_seen++;
            end
        end
        if (rst_n && start && !busy)
        begin
            awaited_results.push_back(apply_command(command, operand_value, position));
            cmd_seen[command]++;
            taken <= 1'b1;
        end
        else
            taken <= 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Main sequence: build the item queue, reset, wait for the end
    // ---------------------------------------------------------------
    initial
    begin : main
        int issued;
        int kind;
        int len;
        int third;
        logic [2:0] cmd;

        foreach (cmd_seen[i])
            cmd_seen[i] = 0;
        foreach (value_pool[i])
            value_pool[i] = $urandom;
        // extremes always in the pool
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;

        // Directed: empty-list misses, both ends, duplicates, close-up, spare codes, clear
        gap_now = 7;
        queue_item(CMD_READ,   32'h0,         6'd0);    // read on empty list
        queue_item(CMD_DELETE, 32'h5,         6'd0);    // delete on empty list
        queue_item(CMD_SEARCH, 32'h0,         6'd0);
        queue_item(CMD_APPEND, 32'h7FFF_FFFF, 6'd0);
        queue_item(CMD_INSERT, 32'h8000_0000, 6'd63);
        queue_item(CMD_APPEND, 32'h0,         6'd0);
        queue_item(CMD_APPEND, 32'hFFFF_FFFF, 6'd0);
        queue_item(CMD_APPEND, 32'h7FFF_FFFF, 6'd0);    // duplicate of entry 1
        queue_item(CMD_SEARCH, 32'hFFFF_FFFF, 6'd0);
        queue_item(CMD_SEARCH, 32'h0001_2345, 6'd0);    // value absent
        queue_item(CMD_READ,   32'h0,         6'd0);
        queue_item(CMD_READ,   32'h0,         6'd4);
        queue_item(CMD_READ,   32'h0,         6'd5);    // one past the end
        queue_item(CMD_READ,   32'h0,         6'd63);
        queue_item(CMD_DELETE, 32'h7FFF_FFFF, 6'd0);    // first of two equal entries
        queue_item(CMD_READ,   32'h0,         6'd1);
        queue_item(CMD_READ,   32'h0,         6'd3);
        queue_item(CMD_DELETE, 32'h8000_0000, 6'd0);    // front entry
        queue_item(CMD_DELETE, 32'h7FFF_FFFF, 6'd0);    // last entry
        queue_item(CMD_SPARE_A, $urandom,     6'd63);
        queue_item(CMD_SPARE_B, 32'hFFFF_FFFF, 6'd0);
        queue_item(CMD_CLEAR,  32'h0,         6'd0);
        queue_item(CMD_READ,   32'h0,         6'd0);
        queue_item(CMD_INSERT, 32'h1234_5678, 6'd0);    // front wraps after clear
        queue_item(CMD_READ,   32'h0,         6'd0);

        // Random: episodes that fill to capacity, drain, mix, or throw noise.
        // Sender idling by thirds: light, heavy, none.
        issued = 0;
        third = -1;
        while (issued < RANDOM_ITEMS)
        begin
            kind = $urandom_range(99);
            kind = (kind < 35) ? EP_FILL : (kind < 65) ? EP_DRAIN :
                   (kind < 90) ? EP_MIXED : EP_NOISE;
            len = (kind == EP_FILL) ? $urandom_range(100, 60) :
                  (kind == EP_NOISE) ? $urandom_range(20, 5) : $urandom_range(80, 10);
            for (int n = 0; n < len && issued < RANDOM_ITEMS; n++)
            begin
                if (issued * 3 / RANDOM_ITEMS != third)
                begin
                    third = issued * 3 / RANDOM_ITEMS;
                    gap_now = (third == 0) ? 7 : (third == 1) ? 51 : 0;
                    hold_next = 1'b1;   // drain at each change of idling
                end
                else if ($urandom_range(99) == 0)
                    hold_next = 1'b1;
                if (kind == EP_NOISE)
                    queue_item(3'($urandom_range(7)), $urandom, 6'($urandom_range(63)));
                else
                begin
                    cmd = pick_command(kind);
                    queue_item(cmd, pick_value(),
                               6'(($urandom_range(1) != 0) ? $urandom_range(7)
                                                           : $urandom_range(63)));
                end
                issued++;
            end
        end

        // Reset held from the start, released at a falling edge
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (queued_commands.size() != 0 || start || awaited_results.size() != 0)
            @(negedge clk);
        // let any stray result show up
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d results: append %0d, insert %0d, delete %0d, search %0d,",
                 results_seen, cmd_seen[CMD_APPEND], cmd_seen[CMD_INSERT],
                 cmd_seen[CMD_DELETE], cmd_seen[CMD_SEARCH]);
        $display("read %0d, clear %0d, spare %0d; %0d hits, %0d refused as full, %0d mismatches",
                 cmd_seen[CMD_READ], cmd_seen[CMD_CLEAR],
                 cmd_seen[CMD_SPARE_A] + cmd_seen[CMD_SPARE_B], hits_seen, full_seen,
                 fail_count);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### ordered_value_list.f
rtl/ovl_pkg.sv
rtl/ovl_ram.sv
rtl/ordered_value_list.sv
bench/tb_ordered_value_list.sv
